@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the tokenizer RTL.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ hw/rtl/swft_pkg.sv @@
// Package for the stop-word filtering tokenizer: sizes, codes, state type, defaults.
// Depends on nothing.
package swft_pkg;
    localparam int TOKEN_BUF    = 32;
    localparam int STOP_ENTRIES = 64;
    localparam int STOP_LEN     = 8;
    localparam int DEFAULT_WORDS = 61;
    localparam int TCW = $clog2(TOKEN_BUF + 1);
    localparam int TIW = (TOKEN_BUF > 1) ? $clog2(TOKEN_BUF) : 1;

    localparam logic [2:0] ACT_TEXT  = 3'd0;
    localparam logic [2:0] ACT_END   = 3'd1;
    localparam logic [2:0] ACT_ADD   = 3'd2;
    localparam logic [2:0] ACT_REM   = 3'd3;
    localparam logic [2:0] ACT_CLEAR = 3'd4;

    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_EOT  = 2'd1;
    localparam logic [1:0] KIND_ACK  = 2'd2;

    localparam logic [1:0] REG_MIN  = 2'd0;
    localparam logic [1:0] REG_MAX  = 2'd1;
    localparam logic [1:0] REG_CASE = 2'd2;
    localparam logic [1:0] REG_STOP = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT,
        ST_EOT,
        ST_ACK
    } t_state;

    // Command broadcast from the controller to every table cell.
    typedef struct packed {
        logic        clear;
        logic        remove;
        logic        add;
        logic [63:0] chars;
        logic [3:0]  len;
    } t_cell_cmd;

    // Status gathered back from the table cells.
    typedef struct packed {
        logic hit;
        logic full;
    } t_cell_stat;

    function automatic logic [63:0] word_pack(input string s);
        logic [63:0] p;
        p = '0;
        for (int k = 0; k < 8; k++) begin
            if (k < s.len()) p[8*k +: 8] = s[k];
        end
        return p;
    endfunction

    function automatic logic [63:0] default_chars(input int idx);
        case (idx)
            0: return word_pack("a");      1: return word_pack("an");
            2: return word_pack("and");    3: return word_pack("are");
            4: return word_pack("as");     5: return word_pack("at");
            6: return word_pack("be");     7: return word_pack("by");
            8: return word_pack("for");    9: return word_pack("from");
            10: return word_pack("has");   11: return word_pack("he");
            12: return word_pack("in");    13: return word_pack("is");
            14: return word_pack("it");    15: return word_pack("its");
            16: return word_pack("of");    17: return word_pack("on");
            18: return word_pack("that");  19: return word_pack("the");
            20: return word_pack("to");    21: return word_pack("was");
            22: return word_pack("were");  23: return word_pack("will");
            24: return word_pack("with");  25: return word_pack("this");
            26: return word_pack("but");   27: return word_pack("they");
            28: return word_pack("have");  29: return word_pack("had");
            30: return word_pack("what");  31: return word_pack("when");
            32: return word_pack("where"); 33: return word_pack("who");
            34: return word_pack("which"); 35: return word_pack("why");
            36: return word_pack("how");   37: return word_pack("all");
            38: return word_pack("each");  39: return word_pack("every");
            40: return word_pack("both");  41: return word_pack("few");
            42: return word_pack("more");  43: return word_pack("most");
            44: return word_pack("other"); 45: return word_pack("some");
            46: return word_pack("such");  47: return word_pack("no");
            48: return word_pack("nor");   49: return word_pack("not");
            50: return word_pack("only");  51: return word_pack("own");
            52: return word_pack("same");  53: return word_pack("so");
            54: return word_pack("than");  55: return word_pack("too");
            56: return word_pack("very");  57: return word_pack("can");
            58: return word_pack("just");  59: return word_pack("should");
            60: return word_pack("now");
            default: return '0;
        endcase
    endfunction

    function automatic logic [3:0] default_len(input int idx);
        logic [63:0] p;
        logic [3:0]  n;
        p = default_chars(idx);
        n = '0;
        for (int k = 0; k < 8; k++) begin
            if (p[8*k +: 8] != 8'd0) n = 4'(k + 1);
        end
        return n;
    endfunction
endpackage

@@ hw/rtl/swft_if.sv @@
// Valid/ready channel interfaces carrying the tokenizer's request and result payloads.
// Depends on nothing; the payload fields follow the request and result formats.
interface swft_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [7:0]  text_char;
    logic [63:0] word_chars;
    logic [3:0]  word_length;
    modport source (output valid, action, text_char, word_chars, word_length, input ready);
    modport sink   (input valid, action, text_char, word_chars, word_length, output ready);
endinterface

interface swft_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] token_char;
    logic       last_of_token;
    logic       table_status;
    modport source (output valid, kind, token_char, last_of_token, table_status, input ready);
    modport sink   (input valid, kind, token_char, last_of_token, table_status, output ready);
endinterface

@@ hw/rtl/stop_word_filtering_tokenizer.sv @@
// Stop-word filtering tokenizer, top level: token buffer, controller, result register.
// Depends on swft_pkg, swft_if, swft_stop_table and assert_macros.svh.
// Sequencing: a text byte is stored in the token buffer; a closing byte or end of text
// then passes through a compare state and an emit state that sends each kept character,
// then an end-of-text state for the mark. Table requests pass through an acknowledge
// state. A new request is taken only when idle with the single result register empty.
// Reset is synchronous active low; control registers and the table return to their defaults in the same cycle.
`include "assert_macros.svh"
module stop_word_filtering_tokenizer
    import swft_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_index,
    input  logic [5:0]    i_cfg_data,
    swft_in_if.sink       in_ch,
    swft_out_if.source    out_ch
);
    // Configuration registers.
    logic [5:0] r_min_len, r_max_len;
    logic       r_case, r_stop_on;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len <= 6'd1;
            r_max_len <= 6'd32;
            r_case    <= 1'b0;
            r_stop_on <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MIN:  r_min_len <= i_cfg_data;
                REG_MAX:  r_max_len <= i_cfg_data;
                REG_CASE: r_case    <= i_cfg_data[0];
                REG_STOP: r_stop_on <= i_cfg_data[0];
                default:  ;
            endcase
        end
    end

    // Token buffer: each new character is written at the fill count and, during
    // emission, characters are read out by index one per cycle while the output is not stalled.
    logic [7:0]     r_tok [TOKEN_BUF];
    logic [TCW-1:0] r_count, n_count;
    logic [TCW-1:0] r_emit;
    logic           r_ovf;
    t_state         r_state, n_state;
    logic           r_is_end;
    logic [1:0]     r_kind;
    logic           r_status;
    logic [63:0]    r_wchars;
    logic [3:0]     r_wlen;
    logic [2:0]     r_tact;

    logic           w_take, w_alnum, w_shift, w_pass, w_emit_ld;
    logic [7:0]     w_ch;
    t_cell_cmd      w_cmd;
    t_cell_cmd      w_cmd_q;
    t_cell_stat     w_stat;
    logic [63:0]    w_packed, w_mask;
    logic           w_wlen_ok;

    assign w_take = in_ch.valid && in_ch.ready;
    assign w_alnum = (in_ch.text_char >= "0" && in_ch.text_char <= "9") ||
                     (in_ch.text_char >= "A" && in_ch.text_char <= "Z") ||
                     (in_ch.text_char >= "a" && in_ch.text_char <= "z");
    assign w_ch = (!r_case && in_ch.text_char >= "A" && in_ch.text_char <= "Z") ?
                  (in_ch.text_char + 8'd32) : in_ch.text_char;

    // Packed view of the first bytes for the table compare.
    always_comb begin
        w_packed = '0;
        for (int k = 0; k < 8; k++) begin
            if (k < TOKEN_BUF && TCW'(k) < r_count) w_packed[8*k +: 8] = r_tok[k];
        end
    end

    assign w_wlen_ok = (in_ch.word_length >= 4'd1) && (in_ch.word_length <= 4'(STOP_LEN));
    always_comb begin
        w_mask = '0;
        for (int k = 0; k < 8; k++) begin
            if (4'(k) < in_ch.word_length) w_mask[8*k +: 8] = 8'hFF;
        end
    end

    // Table command: in the scan state the closed token is looked up; otherwise the
    // word captured with the last request is presented for add, remove and clear.
    always_comb begin
        w_cmd = '0;
        if (r_state == ST_SCAN) begin
            w_cmd.chars = w_packed;
            w_cmd.len   = r_count[3:0];
        end else begin
            w_cmd.chars = r_wchars;
            w_cmd.len   = r_wlen;
        end
    end

    swft_stop_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd_q),
        .o_stat  (w_stat)
    );

    // Table edits are issued in the cycle after the request is captured. A word of
    // invalid length is captured as length zero and never adds or removes an entry.
    always_comb begin
        w_cmd_q        = w_cmd;
        w_cmd_q.add    = (r_state == ST_ACK) && (r_tact == ACT_ADD) &&
                         (r_wlen != 4'd0) && !w_stat.hit;
        w_cmd_q.remove = (r_state == ST_ACK) && (r_tact == ACT_REM);
        w_cmd_q.clear  = (r_state == ST_ACK) && (r_tact == ACT_CLEAR);
    end

    assign w_pass = (r_count != '0) && !r_ovf && (6'(r_count) >= r_min_len) &&
                    (6'(r_count) <= r_max_len) &&
                    !(r_stop_on && r_count <= TCW'(STOP_LEN) && w_stat.hit);

    assign in_ch.ready = (r_state == ST_IDLE) && !out_ch.valid;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_take) begin
                    case (in_ch.action)
                        ACT_TEXT: n_state = w_alnum ? ST_IDLE : ST_SCAN;
                        ACT_END:  n_state = ST_SCAN;
                        ACT_ADD, ACT_REM, ACT_CLEAR: n_state = ST_ACK;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN: n_state = w_pass ? ST_EMIT : (r_is_end ? ST_EOT : ST_IDLE);
            ST_EMIT: if (!out_ch.valid || out_ch.ready) begin
                n_state = (r_emit + 1'b1 == r_count) ? (r_is_end ? ST_EOT : ST_IDLE) : ST_EMIT;
            end
            ST_EOT:  if (!out_ch.valid || out_ch.ready) n_state = ST_IDLE;
            ST_ACK:  if (!out_ch.valid || out_ch.ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Output-side control decoded from the state.
    always_comb begin
        w_shift   = (r_state == ST_EMIT) && (!out_ch.valid || out_ch.ready);
        w_emit_ld = w_shift;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_count = r_count;
        if (w_take && in_ch.action == ACT_TEXT && w_alnum && r_count < TCW'(TOKEN_BUF))
            n_count = r_count + 1'b1;
        if ((r_state == ST_SCAN && !w_pass) ||
            (r_state == ST_EMIT && w_shift && r_emit + 1'b1 == r_count))
            n_count = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_emit   <= '0;
            r_is_end <= 1'b0;
            r_tact   <= ACT_TEXT;
        end else begin
            r_count <= n_count;
            if (n_count == '0)
                r_ovf <= 1'b0;
            else if (w_take && in_ch.action == ACT_TEXT && w_alnum &&
                     r_count == TCW'(TOKEN_BUF))
                r_ovf <= 1'b1;
            if (r_state == ST_SCAN) r_emit <= '0;
            else if (w_shift)       r_emit <= r_emit + 1'b1;
            if (w_take) begin
                r_is_end <= (in_ch.action == ACT_END);
                r_tact   <= in_ch.action;
            end
        end
    end

    // Token buffer writes and the captured table word.
    always_ff @(posedge i_clk) begin
        if (w_take && in_ch.action == ACT_TEXT && w_alnum && r_count < TCW'(TOKEN_BUF))
            r_tok[r_count[TIW-1:0]] <= w_ch;
        if (w_take) begin
            r_wchars <= in_ch.word_chars & w_mask;
            r_wlen   <= w_wlen_ok ? in_ch.word_length : 4'd0;
        end
    end

    // Result register.
    logic       r_ovalid;
    logic [7:0] r_ochar;
    logic       r_olast;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_emit_ld) begin
            r_ovalid <= 1'b1;
            r_kind   <= KIND_CHAR;
            r_ochar  <= r_tok[r_emit[TIW-1:0]];
            r_olast  <= (r_emit + 1'b1 == r_count);
            r_status <= 1'b0;
        end else if (r_state == ST_EOT && (!out_ch.valid || out_ch.ready)) begin
            r_ovalid <= 1'b1;
            r_kind   <= KIND_EOT;
            r_ochar  <= '0;
            r_olast  <= 1'b0;
            r_status <= 1'b0;
        end else if (r_state == ST_ACK && (!out_ch.valid || out_ch.ready)) begin
            r_ovalid <= 1'b1;
            r_kind   <= KIND_ACK;
            r_ochar  <= '0;
            r_olast  <= 1'b0;
            r_status <= (r_tact == ACT_ADD) && (r_wlen != 4'd0) &&
                        !w_stat.hit && w_stat.full;
        end else if (out_ch.valid && out_ch.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign out_ch.valid         = r_ovalid;
    assign out_ch.kind          = r_kind;
    assign out_ch.token_char    = r_ochar;
    assign out_ch.last_of_token = r_olast;
    assign out_ch.table_status  = r_status;

    `ASSERT_IMPL(a_no_take_busy, i_clk, i_rst_n, r_state != ST_IDLE, !in_ch.ready,
        "request accepted while busy")
    `ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= TCW'(TOKEN_BUF),
        "token count beyond buffer")
    `ASSERT_NEXT(a_ack_result, i_clk, i_rst_n, r_state == ST_ACK && !out_ch.valid,
        out_ch.valid && out_ch.kind == KIND_ACK, "acknowledge missing")
endmodule

@@ hw/rtl/swft_stop_cell.sv @@
// One stop-word table cell: holds an entry and compares it with a broadcast word.
// Depends on swft_pkg. Free-slot claim passes along the chain as a token.
module swft_stop_cell
    import swft_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [63:0] i_def_chars,
    input  logic [3:0]  i_def_len,
    input  logic        i_def_valid,
    input  t_cell_cmd   i_cmd,
    input  logic        i_claim_in,
    output logic        o_claim_out,
    output logic        o_hit,
    output logic        o_valid
);
    logic        r_valid;
    logic [63:0] r_chars;
    logic [3:0]  r_len;
    logic        w_take;

    assign o_hit = r_valid && (r_len == i_cmd.len) && (r_chars == i_cmd.chars);
    // The first free cell on the chain takes the add; later cells see no claim.
    assign w_take      = i_cmd.add && i_claim_in && !r_valid;
    assign o_claim_out = i_claim_in && r_valid;
    assign o_valid     = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= i_def_valid;
            r_chars <= i_def_chars;
            r_len   <= i_def_len;
        end else if (i_cmd.clear) begin
            r_valid <= 1'b0;
        end else if (i_cmd.remove && o_hit) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
            r_chars <= i_cmd.chars;
            r_len   <= i_cmd.len;
        end
    end
endmodule

@@ hw/rtl/swft_stop_table.sv @@
// Stop-word table: a chain of cells, reset to the default word list.
// Depends on swft_pkg and swft_stop_cell.
module swft_stop_table
    import swft_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_cmd  i_cmd,
    output t_cell_stat o_stat
);
    logic [STOP_ENTRIES:0]   w_claim;
    logic [STOP_ENTRIES-1:0] w_hit;
    logic [STOP_ENTRIES-1:0] w_valid;

    assign w_claim[0] = 1'b1;

    for (genvar g = 0; g < STOP_ENTRIES; g++) begin : g_cell
        swft_stop_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_def_chars (default_chars(g)),
            .i_def_len   (default_len(g)),
            .i_def_valid (g < DEFAULT_WORDS),
            .i_cmd       (i_cmd),
            .i_claim_in  (w_claim[g]),
            .o_claim_out (w_claim[g+1]),
            .o_hit       (w_hit[g]),
            .o_valid     (w_valid[g])
        );
    end

    assign o_stat.hit  = |w_hit;
    assign o_stat.full = &w_valid;
endmodule
